// ===== src/vector_euclidean_distance_assert.svh =====
// Assertion macros for the vector Euclidean distance block
`ifndef VECTOR_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define VECTOR_EUCLIDEAN_DISTANCE_ASSERT_SVH
`ifndef SYNTH
`define VED_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VED_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VED_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VED_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/ved_pkg.sv =====
// ----------------------------------------------------------------------------
// ved_pkg
// Shared constants and types for the vector Euclidean distance block.
// ----------------------------------------------------------------------------
package ved_pkg;
    localparam int DEF_MAX_ELEMENTS  = 1024;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int ELEM_W  = 24;
    localparam int DIFF_W  = 60;
    localparam int REFS_W  = 58;
    localparam int DIST_W  = 30;
    localparam int PCT_W   = 32;
    localparam int ROOT_W  = 32;

    typedef struct packed {
        logic [DIFF_W-1:0] diff_sum;
        logic [REFS_W-1:0] ref_sum;
        logic              sat;
    } t_job;
endpackage

// ===== src/ved_front.sv =====
// ----------------------------------------------------------------------------
// ved_front
// Accepts element pairs, accumulates saturating square sums, and pushes a
// job at each final element.
// ----------------------------------------------------------------------------
module ved_front #(
    parameter int MAX_ELEMENTS = ved_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ved_pkg::ELEM_W-1:0] i_reference_value,
    input  logic signed [ved_pkg::ELEM_W-1:0] i_current_value,
    input  logic                              i_final_element,
    output logic                              o_job_valid,
    output ved_pkg::t_job                     o_job,
    input  logic                              i_job_full
);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [ved_pkg::DIFF_W-1:0] DIFF_MAX = '1;
    localparam logic [ved_pkg::REFS_W-1:0] REFS_MAX = '1;

    logic [ved_pkg::DIFF_W-1:0] r_diff, n_diff;
    logic [ved_pkg::REFS_W-1:0] r_refs, n_refs;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_sat, n_sat;

    // stage 1: squares registered
    logic                       r_s1_v, r_s1_last;
    logic [49:0]                r_dsq;
    logic [47:0]                r_rsq;
    logic                       r_s1_csat;

    logic signed [ved_pkg::ELEM_W:0] w_d;
    logic [ved_pkg::ELEM_W:0]        w_da;
    logic [ved_pkg::ELEM_W-1:0]      w_ra;
    logic                            w_acc;
    logic [ved_pkg::DIFF_W:0]        w_dsum;
    logic [ved_pkg::REFS_W:0]        w_rsum;

    assign o_stall = i_job_full;
    assign w_acc   = i_valid && !o_stall;
    assign w_d     = (ved_pkg::ELEM_W+1)'(i_current_value) - (ved_pkg::ELEM_W+1)'(i_reference_value);
    assign w_da    = w_d[ved_pkg::ELEM_W] ? ved_pkg::ELEM_W'(0) - w_d : w_d;
    assign w_ra    = i_reference_value[ved_pkg::ELEM_W-1] ?
                     ved_pkg::ELEM_W'(0) - i_reference_value : i_reference_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_acc;
        end
        if (w_acc) begin
            r_dsq     <= 50'(w_da) * 50'(w_da);
            r_rsq     <= 48'(w_ra) * 48'(w_ra);
            r_s1_last <= i_final_element;
        end
    end

    always_comb begin
        n_diff = r_diff;
        n_refs = r_refs;
        n_cnt  = r_cnt;
        n_sat  = r_sat;
        w_dsum = {1'b0, r_diff} + (ved_pkg::DIFF_W+1)'(r_dsq);
        w_rsum = {1'b0, r_refs} + (ved_pkg::REFS_W+1)'(r_rsq);
        if (r_s1_v) begin
            if (r_cnt >= CNT_MAX) begin
                n_sat = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            if (w_dsum[ved_pkg::DIFF_W]) begin
                n_diff = DIFF_MAX;
                n_sat  = 1'b1;
            end else begin
                n_diff = w_dsum[ved_pkg::DIFF_W-1:0];
            end
            if (w_rsum[ved_pkg::REFS_W]) begin
                n_refs = REFS_MAX;
                n_sat  = 1'b1;
            end else begin
                n_refs = w_rsum[ved_pkg::REFS_W-1:0];
            end
        end
    end

    assign o_job_valid     = r_s1_v && r_s1_last;
    assign o_job.diff_sum  = n_diff;
    assign o_job.ref_sum   = n_refs;
    assign o_job.sat       = n_sat;
    assign r_s1_csat       = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= '0;
            r_refs <= '0;
            r_cnt  <= '0;
            r_sat  <= 1'b0;
        end else if (o_job_valid) begin
            r_diff <= '0;
            r_refs <= '0;
            r_cnt  <= '0;
            r_sat  <= r_s1_csat;
        end else begin
            r_diff <= n_diff;
            r_refs <= n_refs;
            r_cnt  <= n_cnt;
            r_sat  <= n_sat;
        end
    end
endmodule

// ===== src/ved_queue.sv =====
// ----------------------------------------------------------------------------
// ved_queue
// Short job queue between front and back. Full leaves one slot spare for
// the job already in the square stage.
// ----------------------------------------------------------------------------
module ved_queue #(
    parameter int DEPTH = ved_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ved_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    output ved_pkg::t_job o_data,
    input  logic          i_pop
);
    localparam int AW = $clog2(DEPTH);
    ved_pkg::t_job    r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt >= (AW+1)'(DEPTH - 1);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && o_valid);
        end
    end
endmodule

// ===== src/ved_back.sv =====
// ----------------------------------------------------------------------------
// ved_back
// Takes one job, runs two bit-serial square roots, then a restoring divide
// for a nonzero-reference percent, and holds the result until taken.
// ----------------------------------------------------------------------------
`include "vector_euclidean_distance_assert.svh"
module ved_back #(
    parameter int FRACTION_BITS = ved_pkg::DEF_FRACTION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  ved_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ved_pkg::DIST_W-1:0]  o_distance,
    output logic [ved_pkg::PCT_W-1:0]   o_relative_percent,
    output logic                        o_zero_reference,
    output logic                        o_overflowed
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam int NUM_W = 32 + 7 + FRACTION_BITS;
    localparam int QW    = NUM_W;
    localparam int CW    = $clog2(QW + 1);

    logic [2:0]  r_st;
    logic [5:0]  r_step;
    logic [63:0] r_dx, r_dres, r_lx, r_lres, r_bit;
    logic        r_sat;
    logic [NUM_W-1:0] r_num;
    logic [QW-1:0]    r_q;
    logic [32:0]      r_rem;
    logic [CW-1:0]    r_dc;
    logic [63:0]      w_dt, w_lt;
    logic [33:0]      w_rs;

    assign o_job_pop = (r_st == S_IDLE) && i_job_valid;
    assign o_valid   = (r_st == S_OUT);
    assign w_dt      = r_dres + r_bit;
    assign w_lt      = r_lres + r_bit;
    assign w_rs      = {r_rem, r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_dx   <= 64'(i_job.diff_sum);
                        r_lx   <= 64'(i_job.ref_sum);
                        r_dres <= '0;
                        r_lres <= '0;
                        r_bit  <= 64'd1 << 62;
                        r_sat  <= i_job.sat;
                        r_st   <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_dx >= w_dt) begin
                        r_dx   <= r_dx - w_dt;
                        r_dres <= (r_dres >> 1) + r_bit;
                    end else begin
                        r_dres <= r_dres >> 1;
                    end
                    if (r_lx >= w_lt) begin
                        r_lx   <= r_lx - w_lt;
                        r_lres <= (r_lres >> 1) + r_bit;
                    end else begin
                        r_lres <= r_lres >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num <= NUM_W'(39'(r_dres[31:0]) * 39'd100) << FRACTION_BITS;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_dc  <= CW'(QW);
                    r_st  <= (r_lres == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    if (w_rs >= 34'(r_lres[31:0])) begin
                        r_rem <= 33'(w_rs - 34'(r_lres[31:0]));
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rs[32:0];
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_dc  <= r_dc - CW'(1);
                    if (r_dc == CW'(1)) begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign r_step             = '0;
    assign o_distance         = r_dres[ved_pkg::DIST_W-1:0];
    assign o_zero_reference   = (r_lres == '0);
    assign o_overflowed       = r_sat;
    assign o_relative_percent = o_zero_reference ? '0 :
                                (|r_q[QW-1:32] ? '1 : r_q[31:0]) | 32'(r_step);

    `VED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_distance), "result dropped while stalled")
    `VED_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_job_pop |-> !o_valid, "job taken while busy")
    `VED_ASSERT_NEXT(a_zero_pct, i_clk, i_rst_n, 1'b1, !(o_valid && o_zero_reference) || o_relative_percent == '0, "nonzero percent on zero reference")
endmodule

// ===== src/vector_euclidean_distance.sv =====
// The final element's job passes the square register and the job queue to the
// back end: a 32-step square root, one multiply step, a 39+FRACTION_BITS step
// divide (skipped on a zero reference), then o_valid. Throughput: one element
// pair per cycle while o_stall is low; the back end takes a new job only after
// its last result is taken; a four-job queue absorbs short vectors.
// Reset: synchronous active low; clears sums, counts, queue and state.
// ----------------------------------------------------------------------------
// vector_euclidean_distance
// Front accumulator, job queue and root/divide back end.
// ----------------------------------------------------------------------------
module vector_euclidean_distance #(
    parameter int MAX_ELEMENTS  = ved_pkg::DEF_MAX_ELEMENTS,
    parameter int FRACTION_BITS = ved_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ved_pkg::ELEM_W-1:0] i_reference_value,
    input  logic signed [ved_pkg::ELEM_W-1:0] i_current_value,
    input  logic                              i_final_element,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ved_pkg::DIST_W-1:0]        o_distance,
    output logic [ved_pkg::PCT_W-1:0]         o_relative_percent,
    output logic                              o_zero_reference,
    output logic                              o_overflowed
);
    logic          w_push, w_full, w_qv, w_pop;
    ved_pkg::t_job w_jin, w_jout;

    ved_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_reference_value, .i_current_value, .i_final_element,
        .o_job_valid(w_push), .o_job(w_jin), .i_job_full(w_full)
    );

    ved_queue #(.DEPTH(ved_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_jin), .o_full(w_full),
        .o_valid(w_qv), .o_data(w_jout), .i_pop(w_pop)
    );

    ved_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_qv), .i_job(w_jout), .o_job_pop(w_pop),
        .o_valid, .i_stall, .o_distance, .o_relative_percent,
        .o_zero_reference, .o_overflowed
    );
endmodule
